FILE: rtl/ssew_pkg.sv
// shared types, constants and saturation helpers for the scanline span edge walker
// used by ssew_div and scanline_span_edge_walker; depends on nothing
`default_nettype none

package ssew_pkg;

  localparam int unsigned SCREEN_W  = 1024;
  localparam int unsigned SCREEN_H  = 1024;
  localparam int unsigned FRAC_BITS = 30;
  localparam int unsigned NUM_SLOTS = 3;

  // pipelined restoring divider: one quotient bit per stage
  localparam int unsigned DIV_STEPS = 31;
  localparam int unsigned DIV_DEPTH = DIV_STEPS + 1;
  localparam int unsigned DIV_W     = 47;

  localparam int unsigned IN_TDATA_W  = 144;
  localparam int unsigned OUT_TDATA_W = 216;

  typedef logic signed [15:0] coord_t;
  typedef logic signed [32:0] attr_t;
  typedef logic signed [17:0] ydiff_t;
  typedef logic signed [17:0] pix_t;
  typedef logic signed [47:0] xfix_t;
  typedef logic [DIV_W-1:0]     dmag_t;
  typedef logic [DIV_STEPS-1:0] quo_t;

  localparam ydiff_t Y_LAST = ydiff_t'(SCREEN_H - 1);
  localparam pix_t   X_LAST = pix_t'(SCREEN_W - 1);

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef enum logic [1:0] {
    FR_ZERO,
    FR_ONE,
    FR_DIV
  } frac_mode_e;

  typedef struct packed {
    coord_t      xa;
    coord_t      xb;
    attr_t [2:0] a;   // u/w, v/w, 1/w at the first end
    attr_t [2:0] b;
  } edge_t;

  typedef struct packed {
    xfix_t       x;
    attr_t [2:0] a;
  } point_t;

  function automatic logic [16:0] mag18(input ydiff_t v);
    logic signed [17:0] n;
    n = -v;
    return v[17] ? n[16:0] : v[16:0];
  endfunction

  function automatic frac_mode_e frac_mode(input ydiff_t num, input ydiff_t den);
    frac_mode_e m;
    if (den == '0 || num == '0 || num[17] != den[17]) begin
      m = FR_ZERO;
    end else if (mag18(num) >= mag18(den)) begin
      m = FR_ONE;
    end else begin
      m = FR_DIV;
    end
    return m;
  endfunction

  function automatic logic signed [31:0] sat_s32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > 52'sd2147483647) begin
      r = S32_MAX;
    end else if (v < -52'sd2147483648) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp_u32(input logic signed [51:0] v);
    logic [31:0] r;
    if (v < 52'sd0) begin
      r = '0;
    end else if (v > 52'sd4294967295) begin
      r = '1;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ssew_div.sv
// pipelined unsigned restoring divider, one quotient bit per register stage
// depends on ssew_pkg; quotient = floor((rem * 2^DIV_STEPS + low) / div), rem < div
`default_nettype none

module ssew_div (
  input  logic             clk_i,
  input  logic             en_i,
  input  ssew_pkg::dmag_t  rem_i,
  input  ssew_pkg::dmag_t  div_i,
  input  ssew_pkg::quo_t   low_i,
  output ssew_pkg::quo_t   quo_o
);
  import ssew_pkg::*;

  dmag_t rem_q [DIV_STEPS];
  dmag_t div_q [DIV_STEPS];
  quo_t  low_q [DIV_STEPS];
  quo_t  quo_q [DIV_DEPTH];

  logic [DIV_W:0] sh     [DIV_STEPS];
  logic           ge     [DIV_STEPS];
  dmag_t          rem_nx [DIV_STEPS];

  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      sh[j] = {rem_q[j], low_q[j][DIV_STEPS-1]};
      ge[j] = sh[j] >= {1'b0, div_q[j]};
      rem_nx[j] = ge[j] ? DIV_W'(sh[j] - {1'b0, div_q[j]}) : sh[j][DIV_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_i;
      div_q[0] <= div_i;
      low_q[0] <= low_i;
      quo_q[0] <= '0;
      for (int j = 1; j < DIV_STEPS; j++) begin
        rem_q[j] <= rem_nx[j-1];
        div_q[j] <= div_q[j-1];
        low_q[j] <= {low_q[j-1][DIV_STEPS-2:0], 1'b0};
      end
      for (int j = 1; j < DIV_DEPTH; j++) begin
        quo_q[j] <= {quo_q[j-1][DIV_STEPS-2:0], ge[j-1]};
      end
    end
  end

  assign quo_o = quo_q[DIV_STEPS];

endmodule

`default_nettype wire

FILE: rtl/scanline_span_edge_walker.sv
// scanline span set-up for one triangle with perspective-correct u/w, v/w, 1/w
// depends on ssew_pkg and ssew_div (edge fraction and per-pixel step dividers)
//
//  channel  dir  tuser       tdata
//  s_axis   in   req_type    slot, x, y, u/w, v/w, 1/w, row
//  m_axis   out  span_empty  start, end, u/w, v/w, 1/w starts, three steps
//
// one item per cycle while m_axis is not stalled
// a row result passes through the two divider pipelines (edge fraction, step)
// a vertex load is written at the accepting edge and gives no result
// reset clears the vertex slots and all valid bits
// a stall on m_axis freezes the whole pipeline; nothing is dropped or repeated
`default_nettype none

module scanline_span_edge_walker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // slot[1:0] x[17:2] y[33:18] uw[65:34] vw[97:66] iw[129:98] row[139:130]
  input  logic [ssew_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // req_type[0]
  input  logic [0:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // start[9:0] end[19:10] uw[51:20] vw[83:52] iw[115:84]
  // uw_step[147:116] vw_step[179:148] iw_step[211:180]
  output logic [ssew_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // span_empty[0]
  output logic [0:0]                           m_axis_tuser
);
  import ssew_pkg::*;

  typedef struct packed {
    logic   outside;
    edge_t  le;
    edge_t  se;
    ydiff_t num_l;
    ydiff_t den_l;
    ydiff_t num_s;
    ydiff_t den_s;
  } prep_t;

  typedef struct packed {
    logic       outside;
    edge_t      le;
    edge_t      se;
    frac_mode_e mode_l;
    frac_mode_e mode_s;
  } frac_side_t;

  typedef struct packed {
    logic        outside;
    attr_t [2:0] la;
    pix_t        px0;
    pix_t        px1;
    logic  [2:0] neg;
    logic  [2:0] sat;
    logic        zero;
  } step_side_t;

  typedef struct packed {
    logic               empty;
    logic [9:0]         start;
    logic [9:0]         stop;
    logic signed [31:0] uw;
    logic signed [31:0] vw;
    logic [31:0]        iw;
    logic signed [31:0] uw_step;
    logic signed [31:0] vw_step;
    logic signed [31:0] iw_step;
  } res_t;

  logic adv, acc;

  // input unpack
  logic [1:0]  in_slot;
  coord_t      in_x, in_y;
  logic [31:0] in_uw, in_vw, in_iw;
  logic [9:0]  in_row;
  logic        in_is_row;

  assign in_slot   = s_axis_tdata[1:0];
  assign in_x      = s_axis_tdata[17:2];
  assign in_y      = s_axis_tdata[33:18];
  assign in_uw     = s_axis_tdata[65:34];
  assign in_vw     = s_axis_tdata[97:66];
  assign in_iw     = s_axis_tdata[129:98];
  assign in_row    = s_axis_tdata[139:130];
  assign in_is_row = s_axis_tuser[0];

  // vertex slots
  coord_t      vx_q [NUM_SLOTS];
  coord_t      vy_q [NUM_SLOTS];
  attr_t [2:0] va_q [NUM_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        vx_q[k] <= '0;
        vy_q[k] <= '0;
        va_q[k] <= '0;
      end
    end else if (acc && !in_is_row) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (in_slot == 2'(k)) begin
          vx_q[k] <= in_x;
          vy_q[k] <= in_y;
          va_q[k] <= {{1'b0, in_iw}, {in_vw[31], in_vw}, {in_uw[31], in_uw}};
        end
      end
    end
  end

  // stage 0: row range, edge choice
  prep_t  p_d;
  ydiff_t yr, y0, y1, y2, r0, r1;
  logic   cond, flat, a_is1, b_is2;

  always_comb begin
    yr = $signed({8'd0, in_row});
    y0 = {{2{vy_q[0][15]}}, vy_q[0]};
    y1 = {{2{vy_q[1][15]}}, vy_q[1]};
    y2 = {{2{vy_q[2][15]}}, vy_q[2]};
    r0 = y0 < 0 ? '0 : y0;
    r1 = y2 > Y_LAST ? Y_LAST : y2;
    cond  = yr < y1 || y2 == y1;
    flat  = y1 == y0;
    a_is1 = !cond || flat;
    b_is2 = !cond;

    p_d.outside = yr < r0 || yr > r1;
    p_d.le.xa = vx_q[0];
    p_d.le.xb = vx_q[2];
    p_d.le.a  = va_q[0];
    p_d.le.b  = va_q[2];
    p_d.se.xa = a_is1 ? vx_q[1] : vx_q[0];
    p_d.se.a  = a_is1 ? va_q[1] : va_q[0];
    p_d.se.xb = b_is2 ? vx_q[2] : vx_q[1];
    p_d.se.b  = b_is2 ? va_q[2] : va_q[1];
    p_d.num_l = yr - y0;
    p_d.den_l = y2 - y0;
    if (!cond) begin
      p_d.num_s = yr - y1;
      p_d.den_s = y2 - y1;
    end else if (flat) begin
      // flat top: the short-edge end sits on the middle vertex
      p_d.num_s = '0;
      p_d.den_s = '0;
    end else begin
      p_d.num_s = yr - y0;
      p_d.den_s = y1 - y0;
    end
  end

  // stage 1: fraction set-up into dividers
  prep_t      p1_q;
  logic       v1_q;
  frac_side_t fs_d;
  quo_t       fq_l, fq_s;

  always_comb begin
    fs_d.outside = p1_q.outside;
    fs_d.le      = p1_q.le;
    fs_d.se      = p1_q.se;
    fs_d.mode_l  = frac_mode(p1_q.num_l, p1_q.den_l);
    fs_d.mode_s  = frac_mode(p1_q.num_s, p1_q.den_s);
  end

  ssew_div u_frac_l (
    .clk_i (clk_i),
    .en_i  (adv),
    .rem_i (DIV_W'(mag18(p1_q.num_l))),
    .div_i (DIV_W'(mag18(p1_q.den_l))),
    .low_i ('0),
    .quo_o (fq_l)
  );

  ssew_div u_frac_s (
    .clk_i (clk_i),
    .en_i  (adv),
    .rem_i (DIV_W'(mag18(p1_q.num_s))),
    .div_i (DIV_W'(mag18(p1_q.den_s))),
    .low_i ('0),
    .quo_o (fq_s)
  );

  frac_side_t fs_q [DIV_DEPTH];
  logic       fv_q [DIV_DEPTH];

  // clamped fractions, Q1.30
  logic [30:0] t_d [2];

  always_comb begin
    t_d[0] = fs_q[DIV_STEPS].mode_l == FR_ONE ? 31'h40000000 :
             fs_q[DIV_STEPS].mode_l == FR_DIV ? {1'b0, fq_l[DIV_STEPS-1:1]} : '0;
    t_d[1] = fs_q[DIV_STEPS].mode_s == FR_ONE ? 31'h40000000 :
             fs_q[DIV_STEPS].mode_s == FR_DIV ? {1'b0, fq_s[DIV_STEPS-1:1]} : '0;
  end

  // stage 2: edge products
  logic        [30:0] t2_q  [2];
  edge_t              ed2_q [2];
  logic               out2_q, v2_q;
  logic signed [48:0] px_d  [2];
  logic signed [65:0] pa_d  [2][3];
  logic signed [16:0] dx;
  logic signed [33:0] da;
  logic signed [31:0] tv;

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      tv = $signed({1'b0, t2_q[e]});
      dx = $signed({ed2_q[e].xb[15], ed2_q[e].xb}) - $signed({ed2_q[e].xa[15], ed2_q[e].xa});
      px_d[e] = dx * tv;
      for (int k = 0; k < 3; k++) begin
        da = $signed({ed2_q[e].b[k][32], ed2_q[e].b[k]})
           - $signed({ed2_q[e].a[k][32], ed2_q[e].a[k]});
        pa_d[e][k] = da * tv;
      end
    end
  end

  // stage 3: edge points
  logic signed [48:0] px3_q [2];
  logic signed [65:0] pa3_q [2][3];
  coord_t             xa3_q [2];
  attr_t [2:0]        a3_q  [2];
  logic               out3_q, v3_q;
  point_t             pt_d  [2];
  logic signed [48:0] xs;
  logic signed [65:0] as;

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      xs = $signed({{3{xa3_q[e][15]}}, xa3_q[e], 30'd0}) + px3_q[e];
      pt_d[e].x = xs[47:0];
      for (int k = 0; k < 3; k++) begin
        as = $signed({{33{a3_q[e][k][32]}}, a3_q[e][k]}) + (pa3_q[e][k] >>> FRAC_BITS);
        pt_d[e].a[k] = as[32:0];
      end
    end
  end

  // stage 4: order ends, width and differences
  point_t             pt4_q [2];
  logic               out4_q, v4_q;
  point_t             lp, rp;
  xfix_t              wfull;
  logic signed [33:0] d_d [3];

  always_comb begin
    if ($signed(pt4_q[0].x) > $signed(pt4_q[1].x)) begin
      lp = pt4_q[1];
      rp = pt4_q[0];
    end else begin
      lp = pt4_q[0];
      rp = pt4_q[1];
    end
    wfull = rp.x - lp.x;
    for (int k = 0; k < 3; k++) begin
      d_d[k] = $signed({rp.a[k][32], rp.a[k]}) - $signed({lp.a[k][32], lp.a[k]});
    end
  end

  // stage 5: step set-up into dividers
  attr_t [2:0]        la5_q;
  logic signed [33:0] d5_q [3];
  dmag_t              w5_q;
  pix_t               px0_5_q, px1_5_q;
  logic               out5_q, v5_q;
  logic [32:0]        mag [3];
  logic signed [33:0] dn;
  step_side_t         ss_d;
  quo_t               sq [3];

  always_comb begin
    ss_d.outside = out5_q;
    ss_d.la      = la5_q;
    ss_d.px0     = px0_5_q;
    ss_d.px1     = px1_5_q;
    ss_d.zero    = w5_q == '0;
    for (int k = 0; k < 3; k++) begin
      dn = -d5_q[k];
      mag[k] = d5_q[k][33] ? dn[32:0] : d5_q[k][32:0];
      ss_d.neg[k] = d5_q[k][33];
      // quotient would reach 2^31
      ss_d.sat[k] = {15'd0, mag[k]} >= {w5_q, 1'b0};
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_step
    ssew_div u_step (
      .clk_i (clk_i),
      .en_i  (adv),
      .rem_i ({15'd0, mag[k][32:1]}),
      .div_i (w5_q),
      .low_i ({mag[k][0], 30'd0}),
      .quo_o (sq[k])
    );
  end

  step_side_t ss_q [DIV_DEPTH];
  logic       sv_q [DIV_DEPTH];

  logic signed [31:0] step_d [3];
  logic signed [31:0] qs;
  step_side_t         so;
  logic [17:0]        lead_d;
  pix_t               px0c_d, px1c_d, pneg;
  logic               empty_d;

  always_comb begin
    so = ss_q[DIV_STEPS];
    for (int k = 0; k < 3; k++) begin
      qs = $signed({1'b0, sq[k]});
      if (so.zero) begin
        step_d[k] = '0;
      end else if (so.sat[k]) begin
        step_d[k] = so.neg[k] ? S32_MIN : S32_MAX;
      end else begin
        step_d[k] = so.neg[k] ? -qs : qs;
      end
    end
    pneg    = -so.px0;
    lead_d  = so.px0 < 0 ? pneg : '0;
    px0c_d  = so.px0 < 0 ? '0 : so.px0;
    px1c_d  = so.px1 > X_LAST ? X_LAST : so.px1;
    empty_d = so.outside || px0c_d > px1c_d;
  end

  // stage 6: start correction products
  logic signed [31:0] step6_q [3];
  logic [17:0]        lead6_q;
  attr_t [2:0]        la6_q;
  pix_t               px0c6_q, px1c6_q;
  logic               empty6_q, v6_q;
  logic signed [50:0] pl_d [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pl_d[k] = step6_q[k] * $signed({1'b0, lead6_q});
    end
  end

  // stage 7: start attributes, saturation
  logic signed [50:0] pl7_q [3];
  logic signed [31:0] step7_q [3];
  attr_t [2:0]        la7_q;
  pix_t               px0c7_q, px1c7_q;
  logic               empty7_q, v7_q;
  logic signed [51:0] sum [3];
  res_t               res_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = $signed({{19{la7_q[k][32]}}, la7_q[k]}) + $signed({pl7_q[k][50], pl7_q[k]});
    end
    res_d = '0;
    res_d.empty = empty7_q;
    if (!empty7_q) begin
      res_d.start   = px0c7_q[9:0];
      res_d.stop    = px1c7_q[9:0];
      res_d.uw      = sat_s32(sum[0]);
      res_d.vw      = sat_s32(sum[1]);
      res_d.iw      = clamp_u32(sum[2]);
      res_d.uw_step = step7_q[0];
      res_d.vw_step = step7_q[1];
      res_d.iw_step = step7_q[2];
    end
  end

  res_t res_q;
  logic out_v_q;

  assign adv = !out_v_q || m_axis_tready;
  assign acc = s_axis_tvalid && adv;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      for (int j = 0; j < DIV_DEPTH; j++) begin
        fv_q[j] <= 1'b0;
        sv_q[j] <= 1'b0;
      end
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      v7_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v1_q    <= s_axis_tvalid && in_is_row;
      fv_q[0] <= v1_q;
      sv_q[0] <= v5_q;
      for (int j = 1; j < DIV_DEPTH; j++) begin
        fv_q[j] <= fv_q[j-1];
        sv_q[j] <= sv_q[j-1];
      end
      v2_q    <= fv_q[DIV_STEPS];
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      v6_q    <= sv_q[DIV_STEPS];
      v7_q    <= v6_q;
      out_v_q <= v7_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q     <= p_d;
      fs_q[0]  <= fs_d;
      ss_q[0]  <= ss_d;
      for (int j = 1; j < DIV_DEPTH; j++) begin
        fs_q[j] <= fs_q[j-1];
        ss_q[j] <= ss_q[j-1];
      end
      t2_q[0]  <= t_d[0];
      t2_q[1]  <= t_d[1];
      ed2_q[0] <= fs_q[DIV_STEPS].le;
      ed2_q[1] <= fs_q[DIV_STEPS].se;
      out2_q   <= fs_q[DIV_STEPS].outside;
      for (int e = 0; e < 2; e++) begin
        px3_q[e] <= px_d[e];
        xa3_q[e] <= ed2_q[e].xa;
        a3_q[e]  <= ed2_q[e].a;
        for (int k = 0; k < 3; k++) begin
          pa3_q[e][k] <= pa_d[e][k];
        end
        pt4_q[e] <= pt_d[e];
      end
      out3_q   <= out2_q;
      out4_q   <= out3_q;
      la5_q    <= lp.a;
      for (int k = 0; k < 3; k++) begin
        d5_q[k]    <= d_d[k];
        step6_q[k] <= step_d[k];
        pl7_q[k]   <= pl_d[k];
        step7_q[k] <= step6_q[k];
      end
      w5_q     <= wfull[DIV_W-1:0];
      px0_5_q  <= lp.x[47:30];
      px1_5_q  <= rp.x[47:30];
      out5_q   <= out4_q;
      lead6_q  <= lead_d;
      la6_q    <= so.la;
      px0c6_q  <= px0c_d;
      px1c6_q  <= px1c_d;
      empty6_q <= empty_d;
      la7_q    <= la6_q;
      px0c7_q  <= px0c6_q;
      px1c7_q  <= px1c6_q;
      empty7_q <= empty6_q;
      res_q    <= res_d;
    end
  end

  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = res_q.empty;
  assign m_axis_tdata  = {4'd0, res_q.iw_step, res_q.vw_step, res_q.uw_step,
                          res_q.iw, res_q.vw, res_q.uw, res_q.stop, res_q.start};

  a_empty_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("empty span carries non-zero fields");

  a_span_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[9:0] <= m_axis_tdata[19:10])
    else $error("span start beyond span end");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> !v1_q)
    else $error("vertex load entered the span pipeline");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(v7_q) && $stable(v1_q))
    else $error("pipeline moved during an output stall");

endmodule

`default_nettype wire
